FILE: hdl/tea_pkg.sv
// ============================================================================
// tea_pkg
// Shared types, constants and the round-sum function of the TEA block cipher.
// ============================================================================
package tea_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned Rounds    = 32;
  localparam int unsigned Stages    = 2 * Rounds;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tea_op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_KEY_ZERO  = 8'd0,
    CFG_KEY_ONE   = 8'd1,
    CFG_KEY_TWO   = 8'd2,
    CFG_KEY_THREE = 8'd3
  } tea_cfg_e;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } tea_key_t;

  typedef struct packed {
    tea_op_e op;
    word_t   v0;
    word_t   v1;
  } tea_blk_t;

  // n times delta, modulo 2^32
  function automatic word_t round_sum(input int unsigned n);
    logic [2*WordW-1:0] prod;
    prod = (2*WordW)'(n) * (2*WordW)'(Delta);
    return prod[WordW-1:0];
  endfunction

endpackage

FILE: hdl/tea_if.sv
// ============================================================================
// tea_if
// Valid/ready channels of the TEA block cipher: block in, result out, config.
// ============================================================================
interface tea_blk_if;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [31:0]          block_first;
  logic [31:0]          block_second;

  modport source (output valid, operation, block_first, block_second, input ready);
  modport sink   (input valid, operation, block_first, block_second, output ready);
endinterface

interface tea_res_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          result_first;
  logic [31:0]          result_second;

  modport source (output valid, result_first, result_second, input ready);
  modport sink   (input valid, result_first, result_second, output ready);
endinterface

interface tea_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tea_cell.sv
// ============================================================================
// tea_cell
// One half-round of TEA: mixes one word of the block into the other and
// registers the block for the next cell.
// ============================================================================
module tea_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tea_pkg::tea_key_t       key_i,
  input  tea_pkg::word_t          sum_enc_i,
  input  tea_pkg::word_t          sum_dec_i,
  input  logic                    phase_i,
  input  logic                    up_valid_i,
  output logic                    up_ready_o,
  input  tea_pkg::tea_blk_t       up_data_i,
  output logic                    dn_valid_o,
  input  logic                    dn_ready_i,
  output tea_pkg::tea_blk_t       dn_data_o
);

  logic              vld_q, vld_d;
  tea_pkg::tea_blk_t data_q, data_d;
  logic              enc;
  logic              upd_first;
  tea_pkg::word_t    sum, src, dst, ka, kb, mix, res;

  always_comb begin
    enc       = (up_data_i.op == tea_pkg::OP_ENCRYPT);
    upd_first = enc ^ phase_i;
    sum       = enc ? sum_enc_i : sum_dec_i;
    src       = upd_first ? up_data_i.v1 : up_data_i.v0;
    dst       = upd_first ? up_data_i.v0 : up_data_i.v1;
    ka        = upd_first ? key_i.k0 : key_i.k2;
    kb        = upd_first ? key_i.k1 : key_i.k3;
    mix       = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    res       = enc ? (dst + mix) : (dst - mix);
  end

  assign up_ready_o = !vld_q || dn_ready_i;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (up_ready_o) begin
      vld_d = up_valid_i;
    end
    if (up_ready_o && up_valid_i) begin
      data_d.op = up_data_i.op;
      data_d.v0 = upd_first ? res : up_data_i.v0;
      data_d.v1 = upd_first ? up_data_i.v1 : res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign dn_valid_o = vld_q;
  assign dn_data_o  = data_q;

endmodule

FILE: hdl/tea_block_cipher.sv
// ============================================================================
// tea_block_cipher
// TEA block cipher, 32 rounds, as a chain of 64 half-round cells.
//
//   channel  dir  payload                                  transaction
//   blk_i    in   operation, block_first, block_second     one block
//   res_o    out  result_first, result_second              one block
//   cfg_i    in   index, data                              one key word
//
// One block enters per cycle unless the first cell is held by a stall;
// each result is registered in each of the 64 half-round cells in turn.
// Reset clears the key words to zero and empties every cell.
// A cell holds only while its successor is full and stalled, so bubbles
// close up and blocks keep entering while a result waits, until the chain is full.
// ============================================================================
module tea_block_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  tea_cfg_if.sink    cfg_i,
  tea_blk_if.sink    blk_i,
  tea_res_if.source  res_o
);

  localparam int unsigned Stages = tea_pkg::Stages;

  tea_pkg::tea_key_t key_q, key_d;
  tea_pkg::tea_blk_t chain_data [Stages+1];
  logic [Stages:0]   chain_vld;
  logic [Stages:0]   chain_rdy;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        tea_pkg::CFG_KEY_ZERO:  key_d.k0 = cfg_i.data;
        tea_pkg::CFG_KEY_ONE:   key_d.k1 = cfg_i.data;
        tea_pkg::CFG_KEY_TWO:   key_d.k2 = cfg_i.data;
        tea_pkg::CFG_KEY_THREE: key_d.k3 = cfg_i.data;
        default:                key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign chain_vld[0]     = blk_i.valid;
  assign blk_i.ready      = chain_rdy[0];
  assign chain_data[0].op = tea_pkg::tea_op_e'(blk_i.operation);
  assign chain_data[0].v0 = blk_i.block_first;
  assign chain_data[0].v1 = blk_i.block_second;

  for (genvar k = 0; k < Stages; k++) begin : g_cell
    localparam int unsigned    Rnd    = k / 2;
    localparam tea_pkg::word_t SumEnc = tea_pkg::round_sum(Rnd + 1);
    localparam tea_pkg::word_t SumDec = tea_pkg::round_sum(tea_pkg::Rounds - Rnd);
    localparam logic           Phase  = 1'(k % 2);

    tea_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key_q),
      .sum_enc_i  (SumEnc),
      .sum_dec_i  (SumDec),
      .phase_i    (Phase),
      .up_valid_i (chain_vld[k]),
      .up_ready_o (chain_rdy[k]),
      .up_data_i  (chain_data[k]),
      .dn_valid_o (chain_vld[k+1]),
      .dn_ready_i (chain_rdy[k+1]),
      .dn_data_o  (chain_data[k+1])
    );
  end

  assign chain_rdy[Stages]   = res_o.ready;
  assign res_o.valid         = chain_vld[Stages];
  assign res_o.result_first  = chain_data[Stages].v0;
  assign res_o.result_second = chain_data[Stages].v1;

`ifndef ASSERT_OFF
  a_enter_first_cell : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_i.valid && blk_i.ready |=> chain_vld[1])
    else $error("accepted block missing from first cell");

  a_empty_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[Stages:1] == '0 |-> blk_i.ready)
    else $error("empty chain refuses a block");

  a_key_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.index == tea_pkg::CFG_KEY_ZERO |=> key_q.k0 == $past(cfg_i.data))
    else $error("key word zero not written");
`endif

endmodule

FILE: dv/tb_tea_block_cipher.sv
// ============================================================================
// tb_tea_block_cipher
// Self-checking bench for the 32-round TEA block cipher.
//
// Encrypt and decrypt transactions go in on the block channel under several
// keys loaded on the config channel. Each result is checked in order against a
// cycle-free software copy of the cipher or a row's known answer. The run opens
// with a fixed vector list that holds the all-zero known answer, then random
// phases with key changes between them, and random gaps on sender and receiver.
// ============================================================================
module tb_tea_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tea_pkg::word_t first;
    tea_pkg::word_t second;
  } blk_res_t;

  typedef struct {
    tea_pkg::tea_op_e op;
    tea_pkg::word_t   v0;
    tea_pkg::word_t   v1;
    bit               known;
    tea_pkg::word_t   exp_first;
    tea_pkg::word_t   exp_second;
  } stim_row_t;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned NumVectors    = 12;

  logic clk_i;
  logic rst_ni;

  tea_cfg_if cfg_if ();
  tea_blk_if blk_if ();
  tea_res_if res_if ();

  tea_block_cipher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .blk_i  (blk_if),
    .res_o  (res_if)
  );

  stim_row_t vector_rows [NumVectors] = '{
    '{tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h41EA_3A0A, 32'h94BA_A940},
    '{tea_pkg::OP_DECRYPT, 32'h41EA_3A0A, 32'h94BA_A940, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{tea_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{tea_pkg::OP_ENCRYPT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0, 32'h0}
  };

  tea_pkg::tea_key_t key_model;
  blk_res_t          pending_blocks [$];
  blk_res_t          last_cipher;
  int unsigned       error_count = 0;
  int unsigned       res_stall_left = 0;
  bit                res_steady;

  function automatic tea_pkg::word_t feistel_mix(tea_pkg::word_t x, tea_pkg::word_t sum,
                                                 tea_pkg::word_t ka, tea_pkg::word_t kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  function automatic blk_res_t tea_transform(tea_pkg::tea_op_e op, tea_pkg::word_t v0,
                                             tea_pkg::word_t v1, tea_pkg::tea_key_t key);
    tea_pkg::word_t sum;
    blk_res_t       res;
    if (op == tea_pkg::OP_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < tea_pkg::Rounds; r++) begin
        sum = sum + tea_pkg::Delta;
        v0  = v0 + feistel_mix(v1, sum, key.k0, key.k1);
        v1  = v1 + feistel_mix(v0, sum, key.k2, key.k3);
      end
    end else begin
      sum = tea_pkg::word_t'(tea_pkg::Delta * tea_pkg::Rounds);
      for (int r = 0; r < tea_pkg::Rounds; r++) begin
        v1  = v1 - feistel_mix(v0, sum, key.k2, key.k3);
        v0  = v0 - feistel_mix(v1, sum, key.k0, key.k1);
        sum = sum - tea_pkg::Delta;
      end
    end
    res.first  = v0;
    res.second = v1;
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 2);
    if (pick < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic tea_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_key(input logic [7:0] idx, input tea_pkg::word_t wdata);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= wdata;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      tea_pkg::CFG_KEY_ZERO:  key_model.k0 = wdata;
      tea_pkg::CFG_KEY_ONE:   key_model.k1 = wdata;
      tea_pkg::CFG_KEY_TWO:   key_model.k2 = wdata;
      tea_pkg::CFG_KEY_THREE: key_model.k3 = wdata;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_block(input tea_pkg::tea_op_e op, input tea_pkg::word_t v0,
                            input tea_pkg::word_t v1, input bit known,
                            input blk_res_t known_res);
    blk_res_t res;
    blk_if.valid        <= 1'b1;
    blk_if.operation    <= op;
    blk_if.block_first  <= v0;
    blk_if.block_second <= v1;
    do @(posedge clk_i); while (!blk_if.ready);
    res = known ? known_res : tea_transform(op, v0, v1, key_model);
    if (op == tea_pkg::OP_ENCRYPT) last_cipher = res;
    pending_blocks.push_back(res);
  endtask

  task automatic sender_pause(input bit steady);
    int unsigned n;
    n = steady ? 0 : gap_len();
    if (n != 0) begin
      blk_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_blocks();
    blk_if.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready   <= 1'b0;
      res_stall_left <= 0;
    end else if (res_stall_left != 0) begin
      res_if.ready   <= 1'b0;
      res_stall_left <= res_stall_left - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (!res_steady && $urandom_range(0, 3) == 0) res_stall_left <= stall_len();
    end
  end

  always @(posedge clk_i) begin
    blk_res_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected result: first=%h second=%h",
               res_if.result_first, res_if.result_second);
        error_count++;
      end else begin
        exp_res = pending_blocks.pop_front();
        if (res_if.result_first !== exp_res.first) begin
          $error("result_first: expected %h, actual %h",
                 exp_res.first, res_if.result_first);
          error_count++;
        end
        if (res_if.result_second !== exp_res.second) begin
          $error("result_second: expected %h, actual %h",
                 exp_res.second, res_if.result_second);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("tb_tea_block_cipher: FAIL");
    $finish;
  end

  initial begin
    blk_res_t         known_res;
    tea_pkg::word_t   phase_key [4];
    tea_pkg::tea_op_e op;
    tea_pkg::word_t   v0;
    tea_pkg::word_t   v1;
    bit               steady;

    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    blk_if.valid        = 1'b0;
    blk_if.operation    = tea_pkg::OP_ENCRYPT;
    blk_if.block_first  = '0;
    blk_if.block_second = '0;
    res_steady          = 1'b0;
    key_model           = '0;
    last_cipher         = '{first: '0, second: '0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // known vectors under the reset key
    for (int i = 0; i < NumVectors; i++) begin
      known_res.first  = vector_rows[i].exp_first;
      known_res.second = vector_rows[i].exp_second;
      send_block(vector_rows[i].op, vector_rows[i].v0, vector_rows[i].v1,
                 vector_rows[i].known, known_res);
      if (i != NumVectors - 1) sender_pause(1'b0);
    end
    drain_blocks();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       phase_key = '{'1, '1, '1, '1};
        1:       phase_key = '{'0, '0, '0, '0};
        2:       phase_key = '{'1, '0, 32'h8000_0000, 32'h0000_0001};
        default: phase_key = '{$urandom, $urandom, $urandom, $urandom};
      endcase
      write_key(tea_pkg::CFG_KEY_ZERO,  phase_key[0]);
      write_key(tea_pkg::CFG_KEY_ONE,   phase_key[1]);
      write_key(tea_pkg::CFG_KEY_TWO,   phase_key[2]);
      write_key(tea_pkg::CFG_KEY_THREE, phase_key[3]);
      write_key(8'($urandom_range(4, 255)), $urandom);

      steady     = (p == 3);
      res_steady = steady;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if ($urandom_range(0, 9) < 2) begin
          op = tea_pkg::OP_DECRYPT;
          v0 = last_cipher.first;
          v1 = last_cipher.second;
        end else begin
          op = tea_pkg::tea_op_e'($urandom_range(0, 1));
          v0 = pick_word();
          v1 = pick_word();
        end
        send_block(op, v0, v1, 1'b0, known_res);
        if (i == ItemsPerPhase - 1) begin
          drain_blocks();
        end else if (p == 2 && i == ItemsPerPhase / 2) begin
          // hold off until the pipeline is empty
          drain_blocks();
        end else begin
          sender_pause(steady);
        end
      end
    end
    res_steady = 1'b0;

    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_tea_block_cipher: PASS");
    end else begin
      $display("tb_tea_block_cipher: FAIL");
    end
    $finish;
  end

endmodule
